// ===== rtl/i8wmva_pkg.sv =====
// Package for the int8-weight matrix-vector accumulator core.
// Holds item types, controller states and the controller/datapath interface.
// No dependencies.
`default_nettype none

package i8wmva_pkg;

  localparam int LANES  = 8;
  localparam int LANE_W = 3;
  localparam int ACC_W  = 40;
  localparam int SCALE_W = 16;
  localparam int ACT_W  = 16;
  localparam int WT_W   = 8;
  localparam int PROD_W = ACT_W + WT_W;
  localparam int SUM_W  = 32;

  // Low and high slices of an accumulator for the two scale partial products.
  localparam int LO_W   = 24;
  localparam int HI_W   = ACC_W - LO_W;
  localparam int LO_P_W = LO_W + SCALE_W;
  localparam int HI_P_W = HI_W + SCALE_W + 1;
  localparam int FULL_W = HI_P_W + LO_W;
  localparam int SHIFT  = 16;

  localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(LANES - 1);

  typedef struct packed {
    logic signed [ACT_W-1:0] activation;
    logic [63:0]             lane_weights;
    logic                    end_of_dot;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_value;
    logic [LANE_W-1:0]       lane_index;
    logic                    last_lane;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_MUL,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic              acc_en;
    logic              mul_en;
    logic              load_out;
    logic              clear;
    logic [LANE_W-1:0] lane;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/i8wmva_ctrl.sv =====
// Controller for the int8-weight matrix-vector accumulator core.
// Sequences accumulation and the per-lane drain; depends on i8wmva_pkg.
`default_nettype none

module i8wmva_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_end,
  output logic                        in_stall,
  input  wire i8wmva_pkg::dp_status_t status,
  output i8wmva_pkg::dp_cmd_t         cmd
);
  import i8wmva_pkg::*;

  state_t            state_r, state_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;
  logic              in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      lane_r  <= '0;
    end else begin
      state_r <= state_nxt;
      lane_r  <= lane_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    lane_nxt     = lane_r;
    in_stall     = 1'b1;
    in_take      = 1'b0;
    cmd.acc_en   = 1'b0;
    cmd.mul_en   = 1'b0;
    cmd.load_out = 1'b0;
    cmd.clear    = 1'b0;
    cmd.lane     = lane_r;
    case (state_r)
      ST_ACC: begin
        in_stall   = 1'b0;
        in_take    = in_valid;
        cmd.acc_en = in_take;
        if (in_take && in_end) begin
          state_nxt = ST_MUL;
          lane_nxt  = '0;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          if (lane_r == LAST_LANE) begin
            cmd.clear = 1'b1;
            state_nxt = ST_ACC;
          end else begin
            lane_nxt  = lane_r + 1'b1;
            state_nxt = ST_MUL;
          end
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/i8wmva_dp.sv =====
// Datapath for the int8-weight matrix-vector accumulator core: lane
// accumulators, scale register, split scale multiply and output register.
// Depends on i8wmva_pkg.
`default_nettype none

module i8wmva_dp (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire i8wmva_pkg::in_item_t   in_item,
  input  wire logic                   cfg_wr_en,
  input  wire logic [15:0]            cfg_wr_data,
  input  wire i8wmva_pkg::dp_cmd_t    cmd,
  output i8wmva_pkg::dp_status_t      status,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output i8wmva_pkg::out_item_t       out_item
);
  import i8wmva_pkg::*;

  logic [ACC_W-1:0]          acc_r [LANES];
  logic [ACC_W-1:0]          acc_nxt [LANES];
  logic [SCALE_W-1:0]        scale_r;
  logic [LO_P_W-1:0]         lo_p_r;
  logic signed [HI_P_W-1:0]  hi_p_r;
  logic [ACC_W-1:0]          acc_sel;
  logic signed [FULL_W-1:0]  full_prod;
  logic signed [FULL_W-SHIFT-1:0] shifted;
  logic signed [SUM_W-1:0]   sat_value;
  logic                      out_valid_r;
  out_item_t                 out_item_r;

  always_comb begin
    logic signed [WT_W-1:0]   wt;
    logic signed [PROD_W-1:0] prod;
    for (int i = 0; i < LANES; i++) begin
      wt         = $signed(in_item.lane_weights[WT_W*i +: WT_W]);
      prod       = in_item.activation * wt;
      acc_nxt[i] = acc_r[i] + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) begin
        acc_r[i] <= '0;
      end
    end else if (cmd.clear) begin
      for (int i = 0; i < LANES; i++) begin
        acc_r[i] <= '0;
      end
    end else if (cmd.acc_en) begin
      for (int i = 0; i < LANES; i++) begin
        acc_r[i] <= acc_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= '0;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  assign acc_sel = acc_r[cmd.lane];

  // The accumulator is split into a signed high part and an unsigned low part.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      lo_p_r <= acc_sel[LO_W-1:0] * scale_r;
      hi_p_r <= $signed(acc_sel[ACC_W-1:LO_W]) * $signed({1'b0, scale_r});
    end
  end

  always_comb begin
    full_prod = $signed({hi_p_r, {LO_W{1'b0}}})
              + $signed({{(FULL_W-LO_P_W){1'b0}}, lo_p_r});
    shifted   = full_prod[FULL_W-1:SHIFT];
    if (shifted[FULL_W-SHIFT-1:SUM_W-1] == '0 ||
        shifted[FULL_W-SHIFT-1:SUM_W-1] == '1) begin
      sat_value = shifted[SUM_W-1:0];
    end else if (shifted[FULL_W-SHIFT-1]) begin
      sat_value = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item_r.sum_value  <= sat_value;
      out_item_r.lane_index <= cmd.lane;
      out_item_r.last_lane  <= (cmd.lane == LAST_LANE);
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_item        = out_item_r;

endmodule

`default_nettype wire

// ===== rtl/int8_weight_matvec_accumulator_core.sv =====
// Top level of the int8-weight matrix-vector accumulator core.
// Instantiates i8wmva_ctrl and i8wmva_dp; depends on i8wmva_pkg.
//
// Each accepted item adds activation times weight into all eight 40-bit lane
// accumulators at once; items without an end mark stream at one per cycle
// while no drain runs. An item with end_of_dot set is accumulated and then the
// eight lanes are drained in lane order: for each result the split scale
// multiplier registers the partial products, then sums them, shifts right,
// saturates and loads the output register once it is free. Input is stalled
// during the drain. The accumulators clear as the last result is loaded, and
// input is taken again while that result waits.
`default_nettype none

module int8_weight_matvec_accumulator_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire i8wmva_pkg::in_item_t in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output i8wmva_pkg::out_item_t     out_item,
  input  wire logic                 cfg_wr_en,
  input  wire logic [15:0]          cfg_wr_data
);
  import i8wmva_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  i8wmva_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_end   (in_item.end_of_dot),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  i8wmva_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

`default_nettype wire

// ===== rtl/i8wmva_chk.sv =====
// Port-level checker for the int8-weight matrix-vector accumulator core,
// bound to the top level. Depends on i8wmva_pkg.
`default_nettype none

module i8wmva_chk (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire i8wmva_pkg::in_item_t  in_item,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire i8wmva_pkg::out_item_t out_item
);
  import i8wmva_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output item changed");

  a_end_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.end_of_dot |=> in_stall)
    else $error("input accepted right after an end of dot product");

  a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_lane |-> in_stall)
    else $error("input accepted during a lane drain");

  a_last_lane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.last_lane == (out_item.lane_index == LAST_LANE)))
    else $error("last lane flag does not match lane index");

endmodule

bind int8_weight_matvec_accumulator_core i8wmva_chk u_i8wmva_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for int8_weight_matvec_accumulator_core.
// Streams directed and random dot-product runs under random valid/stall pacing and checks
// every result against an in-bench lane model or a fixed sum. Depends on i8wmva_pkg.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i8wmva_pkg::*;

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS  = 130;

  typedef enum logic {
    ROW_ITEM,
    ROW_SCALE
  } row_kind_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SPARSE,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  typedef struct {
    row_kind_t               kind;
    logic [15:0]             scale;
    logic [15:0]             activation;
    logic [63:0]             weights;
    logic                    end_of_dot;
    bit                      typed;
    logic signed [SUM_W-1:0] typed_sum;
  } dir_row_t;

  logic      clk;
  logic      rst_n       = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_stall;
  in_item_t  in_item     = '0;
  logic      out_valid;
  logic      out_stall   = 1'b0;
  out_item_t out_item;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  logic signed [ACC_W-1:0] lane_acc [LANES];
  logic [SCALE_W-1:0]      scale_q;
  out_item_t               pending_results [$];
  out_item_t               want_item;
  dir_row_t                directed_rows [$];
  int                      mismatches  = 0;
  int                      cycle_count = 0;
  int                      burst_left  = 0;
  bit                      no_gaps     = 1'b0;
  int                      stall_tick  = 0;
  stall_mode_t             stall_mode  = STALL_NONE;

  int8_weight_matvec_accumulator_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("int8_weight_matvec_accumulator_core: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 128 == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_SPARSE:   out_stall <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall <= (stall_tick % 3 == 1);
      default:        out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual sum=%0d lane=%0d last=%0b",
                 $time, out_item.sum_value, out_item.lane_index, out_item.last_lane);
      end else begin
        want_item = pending_results.pop_front();
        if (out_item.sum_value !== want_item.sum_value ||
            out_item.lane_index !== want_item.lane_index ||
            out_item.last_lane !== want_item.last_lane) begin
          mismatches++;
          $display("%0t: expected sum=%0d lane=%0d last=%0b, actual sum=%0d lane=%0d last=%0b",
                   $time, want_item.sum_value, want_item.lane_index, want_item.last_lane,
                   out_item.sum_value, out_item.lane_index, out_item.last_lane);
        end
      end
    end
  end

  task automatic accumulate_lanes(input in_item_t item, input bit typed,
                                  input logic signed [SUM_W-1:0] typed_sum);
    logic signed [PROD_W-1:0] prod;
    longint                   scaled;
    out_item_t                res;
    for (int i = 0; i < LANES; i++) begin
      prod = $signed(item.activation) * $signed(item.lane_weights[8*i +: 8]);
      lane_acc[i] = lane_acc[i] + prod;
    end
    if (item.end_of_dot) begin
      for (int i = 0; i < LANES; i++) begin
        scaled = (longint'(lane_acc[i]) * longint'(scale_q)) >>> SHIFT;
        if (scaled > 64'sd2147483647) begin
          scaled = 64'sd2147483647;
        end else if (scaled < -64'sd2147483648) begin
          scaled = -64'sd2147483648;
        end
        res.sum_value  = typed ? typed_sum : scaled[SUM_W-1:0];
        res.lane_index = LANE_W'(i);
        res.last_lane  = (i == LANES - 1);
        pending_results.push_back(res);
        lane_acc[i] = '0;
      end
    end
  endtask

  task automatic pace_sender();
    int gap;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_item(input in_item_t item, input bit typed,
                           input logic signed [SUM_W-1:0] typed_sum);
    in_item  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    accumulate_lanes(item, typed, typed_sum);
    pace_sender();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(input logic [15:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    scale_q = value;
    @(posedge clk);
  endtask

  initial begin
    in_item_t    item;
    int          sent;
    int          run_len;
    logic [7:0]  wbyte;
    logic [15:0] pick;

    for (int i = 0; i < LANES; i++) lane_acc[i] = '0;
    scale_q = '0;

    directed_rows.push_back('{ROW_ITEM,  16'h0000, 16'h7FFF, {8{8'h7F}}, 1'b1, 1'b1, 0});
    directed_rows.push_back('{ROW_SCALE, 16'hFFFF, 16'h0000, 64'h0,      1'b0, 1'b0, 0});
    directed_rows.push_back('{ROW_ITEM,  16'h0000, 16'h8000, {8{8'h80}}, 1'b1, 1'b1, 4194240});
    directed_rows.push_back('{ROW_ITEM,  16'h0000, 16'h8000, {8{8'h7F}}, 1'b1, 1'b0, 0});
    directed_rows.push_back('{ROW_ITEM,  16'h0000, 16'h7FFF, 64'h807F01FF0040C002, 1'b0, 1'b0, 0});
    directed_rows.push_back('{ROW_ITEM,  16'h0000, 16'h0001, 64'h0102030405060708, 1'b0, 1'b0, 0});
    directed_rows.push_back('{ROW_ITEM,  16'h0000, 16'hFFFF, 64'hFEDCBA9876543210, 1'b1, 1'b0, 0});
    directed_rows.push_back('{ROW_SCALE, 16'h0001, 16'h0000, 64'h0,      1'b0, 1'b0, 0});
    directed_rows.push_back('{ROW_ITEM,  16'h0000, 16'h1000, {8{8'h01}}, 1'b1, 1'b0, 0});
    directed_rows.push_back('{ROW_ITEM,  16'h0000, 16'hFFFF, {8{8'h01}}, 1'b1, 1'b1, -1});
    directed_rows.push_back('{ROW_SCALE, 16'h8000, 16'h0000, 64'h0,      1'b0, 1'b0, 0});
    directed_rows.push_back('{ROW_ITEM,  16'h0000, 16'hFFFD, {8{8'h01}}, 1'b1, 1'b1, -2});
    directed_rows.push_back('{ROW_ITEM,  16'h0000, 16'h0003, {8{8'h01}}, 1'b1, 1'b1, 1});
    directed_rows.push_back('{ROW_SCALE, 16'h0000, 16'h0000, 64'h0,      1'b0, 1'b0, 0});
    directed_rows.push_back('{ROW_ITEM,  16'h0000, 16'h7FFF, {8{8'h7F}}, 1'b0, 1'b0, 0});
    directed_rows.push_back('{ROW_ITEM,  16'h0000, 16'h8000, {8{8'h80}}, 1'b1, 1'b1, 0});
    directed_rows.push_back('{ROW_SCALE, 16'hFFFF, 16'h0000, 64'h0,      1'b0, 1'b0, 0});
    directed_rows.push_back('{ROW_ITEM,  16'h0000, 16'h5555, {8{8'hAA}}, 1'b0, 1'b0, 0});
    directed_rows.push_back('{ROW_ITEM,  16'h0000, 16'h2AAA, {8{8'h55}}, 1'b0, 1'b0, 0});
    directed_rows.push_back('{ROW_ITEM,  16'h0000, 16'h0000, {8{8'hFF}}, 1'b1, 1'b0, 0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_SCALE) begin
        wait_idle();
        write_scale(directed_rows[r].scale);
      end else begin
        item.activation   = directed_rows[r].activation;
        item.lane_weights = directed_rows[r].weights;
        item.end_of_dot   = directed_rows[r].end_of_dot;
        send_item(item, directed_rows[r].typed, directed_rows[r].typed_sum);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        wait_idle();
        case ($urandom_range(0, 4))
          0:       pick = 16'h0000;
          1:       pick = 16'hFFFF;
          2:       pick = 16'h0001;
          default: pick = 16'($urandom_range(0, 65535));
        endcase
        write_scale(pick);
      end else if ($urandom_range(0, 9) == 0 || sent == RANDOM_ITEMS / 2) begin
        wait_idle();
      end
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 8);
      no_gaps = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < run_len; k++) begin
        case ($urandom_range(0, 7))
          0:       item.activation = 16'h7FFF;
          1:       item.activation = 16'h8000;
          2:       item.activation = 16'hFFFF;
          default: item.activation = 16'($urandom);
        endcase
        for (int b = 0; b < LANES; b++) begin
          case ($urandom_range(0, 9))
            0:       wbyte = 8'h7F;
            1:       wbyte = 8'h80;
            2:       wbyte = 8'h00;
            default: wbyte = 8'($urandom);
          endcase
          item.lane_weights[8*b +: 8] = wbyte;
        end
        item.end_of_dot = (k == run_len - 1);
        send_item(item, 1'b0, '0);
      end
      sent += run_len;
    end
    no_gaps = 1'b0;

    wait_idle();
    if (mismatches == 0) begin
      $display("int8_weight_matvec_accumulator_core: match");
    end else begin
      $display("int8_weight_matvec_accumulator_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
